FILE: rtl/fodr_pkg.sv
// Shared constants, tables, state type and unit command type for the odometry block.
`default_nettype none
package fodr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int CORDIC_CW    = $clog2(CORDIC_N);

  localparam int XW     = 34;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW);
  localparam int SQ_W   = 64;

  localparam logic signed [XW-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [XW-1:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [18:0] PI_Q13     = 19'sd25736;
  localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;

  localparam logic CFG_ANGLE_THRESHOLD = 1'b0;
  localparam logic CFG_MIN_WHEEL_SPEED = 1'b1;

  localparam logic [14:0] ANGLE_THRESHOLD_RST = 15'd1430;
  localparam logic [14:0] MIN_WHEEL_SPEED_RST = 15'd41;

  typedef enum logic [4:0] {
    S_IDLE, S_DOT, S_NPROD, S_SQ1, S_SQ1W, S_DIVQ, S_QQ, S_SQ2, S_SQ2W, S_CV,
    S_SIG, S_EXP, S_SDIV, S_SDIVW, S_BLEND, S_YAW, S_YAW1, S_WRAP, S_TRIG,
    S_TRIGW, S_P0, S_P1, S_P2, S_P3, S_P4, S_DONE
  } fodr_state_t;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } fodr_cordic_cmd_t;

  function automatic logic signed [XW-1:0] atan_q29(input logic [4:0] i);
    logic signed [XW-1:0] v;
    case (i)
      5'd0:  v = 34'sd421657428;
      5'd1:  v = 34'sd248918915;
      5'd2:  v = 34'sd131521918;
      5'd3:  v = 34'sd66762579;
      5'd4:  v = 34'sd33510844;
      5'd5:  v = 34'sd16771757;
      5'd6:  v = 34'sd8387925;
      5'd7:  v = 34'sd4194219;
      5'd8:  v = 34'sd2097141;
      5'd9:  v = 34'sd1048575;
      5'd10: v = 34'sd524288;
      5'd11: v = 34'sd262144;
      5'd12: v = 34'sd131072;
      5'd13: v = 34'sd65536;
      5'd14: v = 34'sd32768;
      5'd15: v = 34'sd16384;
      5'd16: v = 34'sd8192;
      5'd17: v = 34'sd4096;
      5'd18: v = 34'sd2048;
      5'd19: v = 34'sd1024;
      5'd20: v = 34'sd512;
      5'd21: v = 34'sd256;
      5'd22: v = 34'sd128;
      5'd23: v = 34'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [29:0] exp_neg_q30(input logic [3:0] k);
    logic [29:0] v;
    case (k)
      4'd0:  v = 30'd1073610760;
      4'd1:  v = 30'd1073479712;
      4'd2:  v = 30'd1073217664;
      4'd3:  v = 30'd1072693760;
      4'd4:  v = 30'd1071646719;
      4'd5:  v = 30'd1069555701;
      4'd6:  v = 30'd1065385899;
      4'd7:  v = 30'd1057095000;
      4'd8:  v = 30'd1040706261;
      4'd9:  v = 30'd1008687096;
      4'd10: v = 30'd947573834;
      4'd11: v = 30'd836230973;
      4'd12: v = 30'd651257337;
      4'd13: v = 30'd395007542;
      4'd14: v = 30'd145315154;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fused_odometry_dead_reckoning_unit.sv
// Top level: sequencer, shared multiplier and state of the fused odometry integrator.
//
// Usage: one input transaction on in_valid/in_ready carries both velocity
// vectors, both speed/turn-rate pairs and the time step. The block then runs
// alone on that transaction and delivers one result transaction on
// out_valid/out_ready: fused speed and turn rate, the vector angle, the new
// heading and the new x/z positions.
// The run is shorter when the wheel speed is not above min_wheel_speed, or
// when a vector is zero. It is set by the 64-step divider (used up to
// twice), the 32-step square root (used up to twice) and the two CORDIC
// passes; one product a cycle goes through the shared multiplier. in_ready
// is high only between transactions.
// Results sit in an output register; a new transaction is taken while the
// last result waits, and the block holds before writing its own result until
// the receiver takes the old one.
// Reset clears heading and positions and loads the register defaults.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`default_nettype none
module fused_odometry_dead_reckoning_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic        [14:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_vis_vel_x,
  input  wire logic signed [15:0] in_vis_vel_y,
  input  wire logic signed [15:0] in_vis_vel_z,
  input  wire logic signed [15:0] in_whl_vel_x,
  input  wire logic signed [15:0] in_whl_vel_y,
  input  wire logic signed [15:0] in_whl_vel_z,
  input  wire logic signed [15:0] in_whl_speed,
  input  wire logic signed [15:0] in_whl_turn_rate,
  input  wire logic signed [15:0] in_vis_speed,
  input  wire logic signed [15:0] in_vis_turn_rate,
  input  wire logic        [15:0] in_step_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_fused_speed,
  output logic signed [15:0]      out_fused_turn_rate,
  output logic        [14:0]      out_vector_angle,
  output logic signed [15:0]      out_heading,
  output logic signed [31:0]      out_position_x,
  output logic signed [31:0]      out_position_z
);
  import fodr_pkg::*;

  localparam logic [3:0] DOT_LAST = 4'd9;
  localparam logic [3:0] EXP_LAST = 4'd14;
  localparam logic [3:0] BL_LAST  = 4'd4;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sh7fff;
    if (v < -21'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  fodr_state_t state_r, state_nxt;

  logic [14:0] thr_r, minw_r;
  logic signed [15:0] yaw_r;
  logic signed [31:0] pos_x_r, pos_z_r;

  logic signed [15:0] vis_r [0:2];
  logic signed [15:0] whl_r [0:2];
  logic signed [15:0] ws_r, ww_r, vw_r;
  logic signed [16:0] vs_r;
  logic        [15:0] dt_r;

  logic signed [33:0] ip_r;
  logic        [31:0] n1_r, n2_r;
  logic        [28:0] q_r;
  logic        [14:0] ang_r, dmag_r;
  logic               d_neg_r;
  logic        [30:0] m_r;
  logic        [16:0] p_r;
  logic signed [35:0] accv_r;
  logic signed [15:0] v_r, w_r;
  logic signed [18:0] yawt_r;
  logic               flip_r;
  logic signed [16:0] sn_r, cs_r;
  logic        [3:0]  cnt_r;
  logic               ph_r;

  logic signed [XW-1:0]   mul_a, mul_b;
  logic signed [2*XW-1:0] prod_r;

  logic              sq_start, sq_done;
  logic [SQ_W-1:0]   sq_op;
  logic [SQ_W/2-1:0] sq_root;

  logic              dv_start, dv_done;
  logic [DIV_NW-1:0] dv_num, dv_quot;
  logic [DIV_DW-1:0] dv_den;

  fodr_cordic_cmd_t     cd_cmd;
  logic signed [XW-1:0] cd_x0, cd_y0, cd_z0, cd_x, cd_y, cd_z;
  logic                 cd_done;

  logic               load_out;
  logic signed [33:0] ip_abs;
  logic signed [15:0] dsig;
  logic signed [16:0] ws_abs;
  logic        [30:0] num30;
  logic        [31:0] sig_den;
  logic signed [XW-1:0] vt, yaw_a;
  logic signed [17:0] vt_sh;
  logic        [61:0] er_sum;
  logic signed [36:0] bl_sum;
  logic signed [33:0] yd_sum;
  logic signed [18:0] yaw_sum;
  logic signed [XW-1:0] cx_f, cy_f, cx_r, cy_r;
  logic signed [16:0] cx_c, cy_c;
  logic signed [2*XW-1:0] dx_sum, dz_sum;
  logic signed [33:0] px_sum, pz_sum;

  fodr_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .op(sq_op),
    .done(sq_done), .root(sq_root)
  );

  fodr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_quot)
  );

  fodr_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cd_cmd), .x0(cd_x0), .y0(cd_y0),
    .z0(cd_z0), .done(cd_done), .x(cd_x), .y(cd_y), .z(cd_z)
  );

  assign ip_abs  = ip_r[33] ? -ip_r : ip_r;
  assign dsig    = $signed({1'b0, ang_r}) - $signed({1'b0, thr_r});
  assign ws_abs  = ws_r[15] ? -17'(ws_r) : 17'(ws_r);
  assign num30   = d_neg_r ? m_r : 31'h40000000;
  assign sig_den = 32'h40000000 + {1'b0, m_r};
  assign vt      = ip_r[33] ? PI_Q29 - cd_z : cd_z;
  assign vt_sh   = vt_sum_hi(vt);
  assign er_sum  = prod_r[61:0] + 62'h20000000;
  assign bl_sum  = 37'(accv_r) + prod_r[36:0] + 37'sd32768;
  assign yd_sum  = prod_r[33:0] + 34'sd16384;
  assign yaw_sum = 19'(yaw_r) + $signed(yd_sum[33:15]);
  assign yaw_a   = {{2{yaw_r[15]}}, yaw_r, 16'h0000};
  assign cx_f    = flip_r ? -cd_x : cd_x;
  assign cy_f    = flip_r ? -cd_y : cd_y;
  assign cx_r    = cx_f + 34'sd16384;
  assign cy_r    = cy_f + 34'sd16384;
  assign cx_c    = clamp_trig($signed(cx_r[33:15]));
  assign cy_c    = clamp_trig($signed(cy_r[33:15]));
  assign dx_sum  = -prod_r + 68'sd67108864;
  assign dz_sum  = prod_r + 68'sd67108864;
  assign px_sum  = 34'(pos_x_r) + $signed(dx_sum[60:27]);
  assign pz_sum  = 34'(pos_z_r) + $signed(dz_sum[60:27]);

  function automatic logic signed [17:0] vt_sum_hi(input logic signed [XW-1:0] t);
    logic signed [XW-1:0] s;
    s = t + 34'sd32768;
    return s[33:16];
  endfunction

  function automatic logic signed [16:0] clamp_trig(input logic signed [18:0] v);
    if (v > 19'sd32768) return 17'sd32768;
    if (v < -19'sd32768) return -17'sd32768;
    return v[16:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    sq_op     = prod_r[63:0];
    dv_start  = 1'b0;
    dv_num    = {4'h0, ip_abs[31:0], 28'h0};
    dv_den    = sq_root;
    cd_cmd    = '0;
    cd_x0     = 34'(q_r);
    cd_y0     = {3'b000, sq_root[30:0]};
    cd_z0     = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_DOT;
      end
      S_DOT: begin
        case (cnt_r)
          4'd0: begin mul_a = 34'(vis_r[0]); mul_b = 34'(whl_r[0]); end
          4'd1: begin mul_a = 34'(vis_r[0]); mul_b = 34'(vis_r[0]); end
          4'd2: begin mul_a = 34'(whl_r[0]); mul_b = 34'(whl_r[0]); end
          4'd3: begin mul_a = 34'(vis_r[1]); mul_b = 34'(whl_r[1]); end
          4'd4: begin mul_a = 34'(vis_r[1]); mul_b = 34'(vis_r[1]); end
          4'd5: begin mul_a = 34'(whl_r[1]); mul_b = 34'(whl_r[1]); end
          4'd6: begin mul_a = 34'(vis_r[2]); mul_b = 34'(whl_r[2]); end
          4'd7: begin mul_a = 34'(vis_r[2]); mul_b = 34'(vis_r[2]); end
          4'd8: begin mul_a = 34'(whl_r[2]); mul_b = 34'(whl_r[2]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_r == DOT_LAST) state_nxt = S_NPROD;
      end
      S_NPROD: begin
        mul_a = {2'b00, n1_r};
        mul_b = {2'b00, n2_r};
        if (n1_r == '0 || n2_r == '0) state_nxt = S_SIG;
        else state_nxt = S_SQ1;
      end
      S_SQ1: begin
        sq_start  = 1'b1;
        state_nxt = S_SQ1W;
      end
      S_SQ1W: begin
        if (sq_done) begin
          if (sq_root == '0) begin
            state_nxt = S_SIG;
          end else begin
            dv_start  = 1'b1;
            state_nxt = S_DIVQ;
          end
        end
      end
      S_DIVQ: begin
        if (dv_done) state_nxt = S_QQ;
      end
      S_QQ: begin
        mul_a     = 34'(q_r);
        mul_b     = 34'(q_r);
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        sq_op     = 64'h0100000000000000 - {7'h00, prod_r[56:0]};
        sq_start  = 1'b1;
        state_nxt = S_SQ2W;
      end
      S_SQ2W: begin
        if (sq_done) begin
          cd_cmd.start    = 1'b1;
          cd_cmd.vec_mode = 1'b1;
          state_nxt       = S_CV;
        end
      end
      S_CV: begin
        if (cd_done) state_nxt = S_SIG;
      end
      S_SIG: begin
        if (ws_abs > $signed({2'b00, minw_r})) state_nxt = S_EXP;
        else state_nxt = S_YAW;
      end
      S_EXP: begin
        mul_a = 34'(m_r);
        mul_b = 34'(exp_neg_q30(cnt_r));
        if ((ph_r || !dmag_r[cnt_r]) && cnt_r == EXP_LAST) state_nxt = S_SDIV;
      end
      S_SDIV: begin
        dv_num    = {17'h0, num30, 16'h0} + {33'h0, sig_den[31:1]};
        dv_den    = sig_den;
        dv_start  = 1'b1;
        state_nxt = S_SDIVW;
      end
      S_SDIVW: begin
        if (dv_done) state_nxt = S_BLEND;
      end
      S_BLEND: begin
        case (cnt_r)
          4'd0: begin mul_a = 34'(vs_r); mul_b = {17'h0, p_r}; end
          4'd1: begin mul_a = 34'(ws_r); mul_b = {17'h0, 17'h10000 - p_r}; end
          4'd2: begin mul_a = 34'(vw_r); mul_b = {17'h0, p_r}; end
          4'd3: begin mul_a = 34'(ww_r); mul_b = {17'h0, 17'h10000 - p_r}; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_r == BL_LAST) state_nxt = S_YAW;
      end
      S_YAW: begin
        mul_a     = 34'(w_r);
        mul_b     = {18'h0, dt_r};
        state_nxt = S_YAW1;
      end
      S_YAW1: state_nxt = S_WRAP;
      S_WRAP: begin
        if (yawt_r <= PI_Q13 && yawt_r >= -PI_Q13) state_nxt = S_TRIG;
      end
      S_TRIG: begin
        cd_cmd.start = 1'b1;
        cd_x0        = GAIN_Q30;
        cd_y0        = '0;
        if (yaw_a > HALF_PI_Q29) cd_z0 = yaw_a - PI_Q29;
        else if (yaw_a < -HALF_PI_Q29) cd_z0 = yaw_a + PI_Q29;
        else cd_z0 = yaw_a;
        state_nxt = S_TRIGW;
      end
      S_TRIGW: begin
        if (cd_done) state_nxt = S_P0;
      end
      S_P0: begin
        mul_a     = 34'(v_r);
        mul_b     = 34'(sn_r);
        state_nxt = S_P1;
      end
      S_P1: begin
        mul_a     = prod_r[33:0];
        mul_b     = {18'h0, dt_r};
        state_nxt = S_P2;
      end
      S_P2: begin
        mul_a     = 34'(v_r);
        mul_b     = 34'(cs_r);
        state_nxt = S_P3;
      end
      S_P3: begin
        mul_a     = prod_r[33:0];
        mul_b     = {18'h0, dt_r};
        state_nxt = S_P4;
      end
      S_P4: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ANGLE_THRESHOLD_RST;
      minw_r <= MIN_WHEEL_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_THRESHOLD: thr_r  <= cfg_data;
        CFG_MIN_WHEEL_SPEED: minw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= '0;
      pos_x_r <= '0;
      pos_z_r <= '0;
    end else begin
      if (state_r == S_WRAP && yawt_r <= PI_Q13 && yawt_r >= -PI_Q13) yaw_r <= yawt_r[15:0];
      if (state_r == S_P2) pos_x_r <= sat32(px_sum);
      if (state_r == S_P4) pos_z_r <= sat32(pz_sum);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        vis_r[0] <= in_vis_vel_x;
        vis_r[1] <= in_vis_vel_y;
        vis_r[2] <= in_vis_vel_z;
        whl_r[0] <= in_whl_vel_x;
        whl_r[1] <= in_whl_vel_y;
        whl_r[2] <= in_whl_vel_z;
        ws_r     <= in_whl_speed;
        ww_r     <= in_whl_turn_rate;
        vs_r     <= in_whl_speed[15] ? -17'(in_vis_speed) : 17'(in_vis_speed);
        vw_r     <= in_vis_turn_rate;
        dt_r     <= in_step_time;
        ip_r     <= '0;
        n1_r     <= '0;
        n2_r     <= '0;
        ang_r    <= '0;
        cnt_r    <= '0;
      end
      S_DOT: begin
        case (cnt_r)
          4'd1, 4'd4, 4'd7: ip_r <= ip_r + prod_r[33:0];
          4'd2, 4'd5, 4'd8: n1_r <= n1_r + prod_r[31:0];
          4'd3, 4'd6, 4'd9: n2_r <= n2_r + prod_r[31:0];
          default: ;
        endcase
        cnt_r <= cnt_r + 1'b1;
      end
      S_DIVQ: begin
        if (dv_done) begin
          q_r <= (dv_quot > 64'h10000000) ? 29'h10000000 : dv_quot[28:0];
        end
      end
      S_CV: begin
        if (cd_done) begin
          if (vt_sh < 18'sd0) ang_r <= '0;
          else if (vt_sh > 18'sd25736) ang_r <= 15'd25736;
          else ang_r <= vt_sh[14:0];
        end
      end
      S_SIG: begin
        d_neg_r <= dsig[15];
        dmag_r  <= dsig[15] ? 15'(-dsig) : dsig[14:0];
        m_r     <= 31'h40000000;
        cnt_r   <= '0;
        ph_r    <= 1'b0;
        v_r     <= ws_r;
        w_r     <= ww_r;
      end
      S_EXP: begin
        if (ph_r) begin
          m_r   <= er_sum[60:30];
          ph_r  <= 1'b0;
          cnt_r <= cnt_r + 1'b1;
        end else if (dmag_r[cnt_r]) begin
          ph_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_SDIVW: begin
        if (dv_done) begin
          p_r   <= dv_quot[16:0];
          cnt_r <= '0;
        end
      end
      S_BLEND: begin
        case (cnt_r)
          4'd1, 4'd3: accv_r <= prod_r[35:0];
          4'd2: v_r <= sat16($signed(bl_sum[36:16]));
          4'd4: w_r <= sat16($signed(bl_sum[36:16]));
          default: ;
        endcase
        cnt_r <= cnt_r + 1'b1;
      end
      S_YAW1: yawt_r <= yaw_sum;
      S_WRAP: begin
        if (yawt_r > PI_Q13) yawt_r <= yawt_r - TWO_PI_Q13;
        else if (yawt_r < -PI_Q13) yawt_r <= yawt_r + TWO_PI_Q13;
      end
      S_TRIG: flip_r <= (yaw_a > HALF_PI_Q29) || (yaw_a < -HALF_PI_Q29);
      S_TRIGW: begin
        if (cd_done) begin
          cs_r <= cx_c;
          sn_r <= cy_c;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_fused_speed     <= v_r;
      out_fused_turn_rate <= w_r;
      out_vector_angle    <= ang_r;
      out_heading         <= yaw_r;
      out_position_x      <= pos_x_r;
      out_position_z      <= pos_z_r;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/fodr_isqrt.sv
// Iterative integer square root, two operand bits per cycle.
`default_nettype none
module fodr_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [fodr_pkg::SQ_W-1:0] op,
  output logic                           done,
  output logic [fodr_pkg::SQ_W/2-1:0]    root
);
  import fodr_pkg::*;

  logic [SQ_W-1:0] n_r, res_r, bit_r, sum, n_nxt, res_nxt;
  logic            busy_r, done_r, ge;

  assign sum     = res_r + bit_r;
  assign ge      = n_r >= sum;
  assign n_nxt   = ge ? n_r - sum : n_r;
  assign res_nxt = ge ? (res_r >> 1) + bit_r : res_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      busy_r <= !bit_r[0];
      done_r <= bit_r[0];
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= op;
      res_r <= '0;
      bit_r <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy_r) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[SQ_W/2-1:0];
endmodule
`default_nettype wire

FILE: rtl/fodr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module fodr_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [fodr_pkg::DIV_NW-1:0] num,
  input  wire logic [fodr_pkg::DIV_DW-1:0] den,
  output logic                             done,
  output logic [fodr_pkg::DIV_NW-1:0]      quot
);
  import fodr_pkg::*;

  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r, den_r, rem_nxt;
  logic [DIV_DW:0]   rem_sh, rem_sub;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r, ge;

  assign rem_sh  = {rem_r, quo_r[DIV_NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign rem_nxt = ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      busy_r <= cnt_r != DIV_CW'(DIV_NW - 1);
      done_r <= cnt_r == DIV_CW'(DIV_NW - 1);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule
`default_nettype wire

FILE: rtl/fodr_cordic.sv
// Iterative CORDIC, vectoring or rotation, one micro-rotation per cycle.
`default_nettype none
module fodr_cordic (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fodr_pkg::fodr_cordic_cmd_t        cmd,
  input  wire logic signed [fodr_pkg::XW-1:0]    x0,
  input  wire logic signed [fodr_pkg::XW-1:0]    y0,
  input  wire logic signed [fodr_pkg::XW-1:0]    z0,
  output logic                                   done,
  output logic signed [fodr_pkg::XW-1:0]         x,
  output logic signed [fodr_pkg::XW-1:0]         y,
  output logic signed [fodr_pkg::XW-1:0]         z
);
  import fodr_pkg::*;

  logic signed [XW-1:0] x_r, y_r, z_r, xs, ys, at;
  logic [CORDIC_CW-1:0] i_r;
  logic                 busy_r, done_r, vec_r, up, last;

  assign xs   = x_r >>> i_r;
  assign ys   = y_r >>> i_r;
  assign at   = atan_q29(5'(i_r));
  assign up   = vec_r ? !y_r[XW-1] : z_r[XW-1];
  assign last = i_r == CORDIC_CW'(CORDIC_N - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      busy_r <= !last;
      done_r <= last;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= cmd.vec_mode;
      i_r   <= '0;
    end else if (busy_r) begin
      x_r <= up ? x_r + ys : x_r - ys;
      y_r <= up ? y_r - xs : y_r + xs;
      z_r <= up ? z_r + at : z_r - at;
      i_r <= i_r + 1'b1;
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
endmodule
`default_nettype wire

FILE: rtl/fodr_checker.sv
// Port-level assertions for the odometry block and their bind to the top level.
`default_nettype none
module fodr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_heading,
  input wire logic        [14:0] out_vector_angle
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading))
    else $error("stalled result changed");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading <= 16'sd25736 && out_heading >= -16'sd25736))
    else $error("heading out of range");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vector_angle <= 15'd25736)
    else $error("vector angle out of range");

endmodule

bind fused_odometry_dead_reckoning_unit fodr_checker u_fodr_checker (.*);
`default_nettype wire

FILE: tb/tb_fused_odometry_dead_reckoning_unit.sv
// Self-checking testbench for the fused odometry unit with an in-bench fixed-point predictor.
`default_nettype none
module tb_fused_odometry_dead_reckoning_unit;
  import fodr_pkg::*;

  typedef struct {
    logic signed [15:0] vis_x, vis_y, vis_z;
    logic signed [15:0] whl_x, whl_y, whl_z;
    logic signed [15:0] whl_spd, whl_turn, vis_spd, vis_turn;
    logic        [15:0] dt;
  } odo_item_t;

  typedef struct {
    logic signed [15:0] spd;
    logic signed [15:0] turn;
    logic        [14:0] ang;
    logic signed [15:0] hdg;
    logic signed [31:0] px;
    logic signed [31:0] pz;
  } odo_result_t;

  typedef struct {
    bit          fixed;
    odo_result_t res;
  } typed_exp_t;

  localparam longint PI29      = 64'sd1686629713;
  localparam longint HALF_PI29 = 64'sd843314857;
  localparam longint GAIN30    = 64'sd652032874;
  localparam longint ONE30     = 64'sd1073741824;

  localparam longint ARCTAN_TAB [24] = '{
    421657428, 248918915, 131521918, 66762579, 33510844, 16771757,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
  localparam longint DECAY_TAB [15] = '{
    1073610760, 1073479712, 1073217664, 1072693760, 1071646719, 1069555701,
    1065385899, 1057095000, 1040706261, 1008687096, 947573834, 836230973,
    651257337, 395007542, 145315154};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_ANGLE_THRESHOLD;
  logic        [14:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  odo_item_t          cur = '{default: '0};
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_fused_speed, out_fused_turn_rate, out_heading;
  logic        [14:0] out_vector_angle;
  logic signed [31:0] out_position_x, out_position_z;

  fused_odometry_dead_reckoning_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vis_vel_x(cur.vis_x), .in_vis_vel_y(cur.vis_y), .in_vis_vel_z(cur.vis_z),
    .in_whl_vel_x(cur.whl_x), .in_whl_vel_y(cur.whl_y), .in_whl_vel_z(cur.whl_z),
    .in_whl_speed(cur.whl_spd), .in_whl_turn_rate(cur.whl_turn),
    .in_vis_speed(cur.vis_spd), .in_vis_turn_rate(cur.vis_turn),
    .in_step_time(cur.dt),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_fused_speed(out_fused_speed), .out_fused_turn_rate(out_fused_turn_rate),
    .out_vector_angle(out_vector_angle), .out_heading(out_heading),
    .out_position_x(out_position_x), .out_position_z(out_position_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register shadows
  longint      thr_shadow = 1430;
  longint      min_spd_shadow = 41;
  longint      yaw_q13 = 0;
  longint      pos_x = 0;
  longint      pos_z = 0;

  odo_result_t pending_results [$];
  typed_exp_t  typed_q [$];
  int          mismatches = 0;
  int          send_idle = 0;
  int          rcv_idle = 0;
  int          hold_reqs = 0;
  int          hold_taken = 0;
  int          hold_left = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint sat16(input longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint sat32(input longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  function automatic longint angle_between(input odo_item_t it);
    longint          a [3], b [3];
    longint          ip, x, y, z, nx, t;
    longint unsigned n1, n2, r, mag, q, s;
    a = '{it.vis_x, it.vis_y, it.vis_z};
    b = '{it.whl_x, it.whl_y, it.whl_z};
    ip = 0; n1 = 0; n2 = 0; z = 0;
    for (int i = 0; i < 3; i++) begin
      ip += a[i] * b[i];
      n1 += longint'(a[i] * a[i]);
      n2 += longint'(b[i] * b[i]);
    end
    if (n1 == 0 || n2 == 0) return 0;
    r = int_sqrt(n1 * n2);
    if (r == 0) return 0;
    mag = ip < 0 ? longint'(-ip) : longint'(ip);
    q = (mag << 28) / r;
    if (q > (64'd1 << 28)) q = 64'd1 << 28;
    s = int_sqrt((64'd1 << 56) - q * q);
    x = q;
    y = s;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN_TAB[i];
      end
      x = nx;
    end
    t = ip < 0 ? PI29 - z : z;
    t = (t + 32768) >>> 16;
    if (t < 0) t = 0;
    if (t > 25736) t = 25736;
    return t;
  endfunction

  function automatic longint blend_weight(input longint d);
    longint m, mag, num, den;
    mag = (d < 0 ? -d : d) & 15'h7fff;
    m = ONE30;
    for (int k = 0; k < 15; k++)
      if (mag[k]) m = (m * DECAY_TAB[k] + (64'sd1 << 29)) >>> 30;
    den = ONE30 + m;
    num = d >= 0 ? ONE30 : m;
    return ((num << 16) + den / 2) / den;
  endfunction

  task automatic heading_trig(input longint yaw, output longint sn, output longint cs);
    longint a, x, y, nx;
    bit     flip;
    a = yaw * 65536;
    x = GAIN30;
    y = 0;
    flip = 1'b0;
    if (a > HALF_PI29) begin
      a -= PI29;
      flip = 1'b1;
    end else if (a < -HALF_PI29) begin
      a += PI29;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= ARCTAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += ARCTAN_TAB[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    x = (x + 16384) >>> 15;
    y = (y + 16384) >>> 15;
    cs = x > 32768 ? 32768 : (x < -32768 ? -32768 : x);
    sn = y > 32768 ? 32768 : (y < -32768 ? -32768 : y);
  endtask

  task automatic dead_reckon(input odo_item_t it, output odo_result_t res);
    longint ang, ws, ww, vs, vw, dt, p, v, w, sn, cs;
    ang = angle_between(it);
    ws = it.whl_spd;
    ww = it.whl_turn;
    vs = it.vis_spd;
    vw = it.vis_turn;
    dt = it.dt;
    if (ws < 0) vs = -vs;
    if ((ws < 0 ? -ws : ws) > min_spd_shadow) begin
      p = blend_weight(ang - thr_shadow);
      v = sat16((vs * p + ws * (65536 - p) + 32768) >>> 16);
      w = sat16((vw * p + ww * (65536 - p) + 32768) >>> 16);
    end else begin
      v = ws;
      w = ww;
    end
    yaw_q13 = yaw_q13 + ((w * dt + 16384) >>> 15);
    while (yaw_q13 > 25736) yaw_q13 -= 51472;
    while (yaw_q13 < -25736) yaw_q13 += 51472;
    heading_trig(yaw_q13, sn, cs);
    pos_x = sat32(pos_x + ((-(v * sn) * dt + (64'sd1 << 26)) >>> 27));
    pos_z = sat32(pos_z + (((v * cs) * dt + (64'sd1 << 26)) >>> 27));
    res = '{spd: v, turn: w, ang: ang, hdg: yaw_q13, px: pos_x, pz: pos_z};
  endtask

  always @(posedge clk) begin
    odo_result_t r, e;
    typed_exp_t  tx;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        dead_reckon(cur, r);
        tx = typed_q.pop_front();
        pending_results.push_back(tx.fixed ? tx.res : r);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction");
          mismatches++;
        end else begin
          e = pending_results.pop_front();
          if (out_fused_speed !== e.spd) begin
            $error("fused_speed exp %0d got %0d", e.spd, out_fused_speed); mismatches++;
          end
          if (out_fused_turn_rate !== e.turn) begin
            $error("fused_turn_rate exp %0d got %0d", e.turn, out_fused_turn_rate);
            mismatches++;
          end
          if (out_vector_angle !== e.ang) begin
            $error("vector_angle exp %0d got %0d", e.ang, out_vector_angle); mismatches++;
          end
          if (out_heading !== e.hdg) begin
            $error("heading exp %0d got %0d", e.hdg, out_heading); mismatches++;
          end
          if (out_position_x !== e.px) begin
            $error("position_x exp %0d got %0d", e.px, out_position_x); mismatches++;
          end
          if (out_position_z !== e.pz) begin
            $error("position_z exp %0d got %0d", e.pz, out_position_z); mismatches++;
          end
        end
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_reqs != hold_taken) begin
      hold_taken <= hold_reqs;
      hold_left <= 1500;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_item(input odo_item_t it, input bit fixed, input odo_result_t res);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_q.push_back('{fixed: fixed, res: res});
    in_valid <= 1'b1;
    cur <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[14:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ANGLE_THRESHOLD) thr_shadow = val;
    else min_spd_shadow = val;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic odo_item_t mk(input int vx, vy, vz, wx, wy, wz,
                                   input int ws, ww, vs, vw, dt);
    odo_item_t it;
    it = '{vx, vy, vz, wx, wy, wz, ws, ww, vs, vw, dt};
    return it;
  endfunction

  function automatic logic signed [15:0] rnd16;
    return $urandom;
  endfunction

  function automatic odo_item_t random_item;
    odo_item_t it;
    int        sel, sz;
    sel = $urandom_range(9);
    it = '{rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
           rnd16(), rnd16(), rnd16(), rnd16(), $urandom};
    if (sel >= 3 && sel <= 5) begin
      sz = $urandom_range(300);
      it.vis_x = it.whl_x / 2 + $signed($urandom_range(2 * sz)) - sz;
      it.vis_y = it.whl_y / 2 + $signed($urandom_range(2 * sz)) - sz;
      it.vis_z = it.whl_z / 2 + $signed($urandom_range(2 * sz)) - sz;
      it.vis_spd = it.whl_spd + $signed($urandom_range(2000)) - 1000;
      it.whl_turn = $signed($urandom_range(8000)) - 4000;
      it.vis_turn = it.whl_turn + $signed($urandom_range(400)) - 200;
    end else if (sel == 6) begin
      it.vis_x = $signed($urandom_range(8)) - 4;
      it.whl_y = $signed($urandom_range(8)) - 4;
      it.dt = $urandom_range(3);
    end else if (sel == 7) begin
      if ($urandom_range(1)) it.vis_x = 0; else it.whl_x = 0;
      if ($urandom_range(1)) begin
        it.vis_x = 0; it.vis_y = 0; it.vis_z = 0;
      end else begin
        it.whl_x = 0; it.whl_y = 0; it.whl_z = 0;
      end
    end else if (sel == 8) begin
      it.whl_spd = min_spd_shadow + $signed($urandom_range(4)) - 2;
      if ($urandom_range(1)) it.whl_spd = -it.whl_spd;
    end else if (sel == 9) begin
      it.whl_spd = -$signed({1'b0, $urandom_range(32767)}) - 1;
      if ($urandom_range(1)) it.vis_spd = 16'sh8000;
    end
    return it;
  endfunction

  odo_item_t   directed_items [$];
  bit          directed_fixed [$];
  odo_result_t directed_res [$];

  initial begin
    odo_result_t none;
    int          cfgs [6][2];
    none = '{default: '0};
    cfgs = '{'{1430, 41}, '{0, 0}, '{25736, 32767}, '{32767, 100},
             '{500, 0}, '{3000, 2000}};

    // reset state, zero step: results read straight off the inputs
    directed_items.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_fixed.push_back(1); directed_res.push_back(none);
    directed_items.push_back(mk(0, 0, 0, 32767, -32768, 1, 41, 32767, -32768, 5, 0));
    directed_fixed.push_back(1);
    directed_res.push_back('{41, 32767, 0, 0, 0, 0});
    directed_items.push_back(mk(-32768, -32768, -32768, 0, 0, 0, -41, -32768, 7, 9, 0));
    directed_fixed.push_back(1);
    directed_res.push_back('{-41, -32768, 0, 0, 0, 0});
    directed_items.push_back(mk(4096, 4096, 4096, 4096, 4096, 4096, 8192, 100, 8000, 50, 1000));
    directed_items.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                                9000, -300, 9000, 300, 4000));
    directed_items.push_back(mk(100, 0, 0, 100, 1, 0, -20000, 32767, -32768, 32767, 65535));
    directed_items.push_back(mk(4096, 0, 0, 0, 4096, 0, -32768, -32768, -32768, -32768, 65535));
    directed_items.push_back(mk(4096, 0, 0, 0, 4096, 0, 32767, -32768, 32767, -32768, 65535));
    directed_items.push_back(mk(1, 2, 3, 3, 2, 1, 30000, 30000, 100, 100, 0));
    directed_items.push_back(mk(0, 0, 5, 0, 0, 5, 0, 32767, 0, 0, 65535));
    directed_items.push_back(mk(0, 0, 5, 0, 0, 5, 0, 32767, 0, 0, 65535));
    directed_items.push_back(mk(0, 0, 5, 0, 0, 5, 0, -32768, 0, 0, 65535));
    directed_items.push_back(mk(7, -7, 7, 7, 7, -7, 5000, 1234, -5000, 4321, 1));
    directed_items.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767, 65535));
    directed_items.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768, 65535));
    directed_items.push_back(mk(1, 0, 0, -1, 0, 0, 42, 0, -42, 0, 65535));
    while (directed_fixed.size() < directed_items.size()) begin
      directed_fixed.push_back(0);
      directed_res.push_back(none);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_items[i])
      send_item(directed_items[i], directed_fixed[i], directed_res[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_ANGLE_THRESHOLD, cfgs[ph][0]);
      write_reg(CFG_MIN_WHEEL_SPEED, cfgs[ph][1]);
      send_idle = ph < 2 ? 36 : (ph < 4 ? 75 : 0);
      rcv_idle  = ph < 2 ? 75 : (ph < 4 ? 36 : 0);
      for (int n = 0; n < 314; n++) begin
        if (n == 40 && (ph == 0 || ph == 4)) hold_reqs++;
        if (n == 150) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        send_item(random_item(), 0, none);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
